// ===== hw/rtl/mre_pkg.sv =====
// Shared types, opcodes, status codes and sizes for the mini RISC executor.
// Used by every module of the block; depends on nothing else.
package mre_pkg;

    localparam int XLEN       = 32;
    localparam int REG_CNT    = 32;
    localparam int RIDX_W     = $clog2(REG_CNT);
    // Program space is a power of two: pc wrap is a plain truncation.
    localparam int PROG_DEPTH = 16384;
    localparam int PC_W       = $clog2(PROG_DEPTH);
    localparam int DATA_DEPTH = 16384;
    localparam int DA_W       = $clog2(DATA_DEPTH);

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 48;

    localparam logic [RIDX_W-1:0] LINK_REG = RIDX_W'(31);
    localparam logic [RIDX_W-1:0] HALT_REG = RIDX_W'(1);

    localparam logic [3:0] OP_NOP  = 4'd0;
    localparam logic [3:0] OP_ADD  = 4'd1;
    localparam logic [3:0] OP_ADDI = 4'd2;
    localparam logic [3:0] OP_SUBI = 4'd3;
    localparam logic [3:0] OP_JR   = 4'd4;
    localparam logic [3:0] OP_JUMP = 4'd5;
    localparam logic [3:0] OP_BEQ  = 4'd6;
    localparam logic [3:0] OP_LW   = 4'd7;
    localparam logic [3:0] OP_SW   = 4'd8;
    localparam logic [3:0] OP_LLI  = 4'd9;
    localparam logic [3:0] OP_BGT  = 4'd10;
    localparam logic [3:0] OP_JAL  = 4'd11;
    localparam logic [3:0] OP_HALT = 4'd12;

    localparam logic [1:0] STAT_RUN     = 2'd0;
    localparam logic [1:0] STAT_HALT    = 2'd1;
    localparam logic [1:0] STAT_BADADDR = 2'd2;
    localparam logic [1:0] STAT_BADOP   = 2'd3;

    // Classified instruction as it travels from front to back.
    typedef struct packed {
        logic [3:0]        cmd;
        logic [RIDX_W-1:0] reg_a;
        logic [RIDX_W-1:0] reg_b;
        logic [RIDX_W-1:0] reg_c;
        logic [XLEN-1:0]   imm;
        logic              src2_c;   // read ports take reg_b/reg_c instead of reg_a/reg_b
        logic              is_load;
        logic              is_store;
        logic              illegal;
    } t_uop;

    typedef struct packed {
        logic [XLEN-1:0] halt_value;
        logic [1:0]      status;
        logic [PC_W-1:0] next_pc;
    } t_result;

endpackage

// ===== hw/rtl/mini_risc_instruction_executor.sv =====
// Top level of the mini RISC executor: front, queue and back connected to
// the stream ports. Depends on mre_pkg, mre_front, mre_queue and mre_back.
//
// Each input item is one instruction fetched at the current pc; each
// accepted item yields exactly one result item carrying the next pc, the
// status (running, halted, data address out of range, undefined opcode) and
// r1 on halt. In the back end an instruction passes a register-file read
// and then an execute-and-write step; a load adds a write-back step, as
// the data memory read is registered. The back end handles one instruction
// at a time since each depends on the pc and registers the last one leaves.
// The front end takes an item in any cycle that its staging register or the
// two-entry queue behind it has room, so items and results flow
// independently; the result register frees as soon as the sink takes it.
// After a stop, later items are consumed and just repeat the final result.
module mini_risc_instruction_executor (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // cmd[3:0], reg_a[8:4], reg_b[13:9], reg_c[18:14], imm[50:19], zero pad
    input  logic [mre_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // next_pc[13:0], status[15:14], halt_value[47:16]
    output logic [mre_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata
);

    logic             w_f_vld;
    logic             w_q_not_full;
    mre_pkg::t_uop    w_f_uop;
    logic             w_q_vld;
    logic             w_q_pop;
    mre_pkg::t_uop    w_q_head;
    mre_pkg::t_result w_res;

    // classify incoming items
    mre_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_uop_vld       (w_f_vld),
        .i_uop_rdy       (w_q_not_full),
        .o_uop           (w_f_uop)
    );

    // hold classified items until the back end is free
    mre_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_f_vld),
        .i_push_uop  (w_f_uop),
        .o_not_full  (w_q_not_full),
        .i_pop       (w_q_pop),
        .o_not_empty (w_q_vld),
        .o_head      (w_q_head)
    );

    // execute and report
    mre_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_vld         (w_q_vld),
        .i_q_uop         (w_q_head),
        .o_q_pop         (w_q_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_res           (w_res)
    );

    assign o_m_axis_tdata = w_res;

endmodule

// ===== hw/rtl/mre_front.sv =====
// Front end of the mini RISC executor: accepts instruction items, unpacks
// and classifies them into one staging register. Depends on mre_pkg.
module mre_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // cmd[3:0], reg_a[8:4], reg_b[13:9], reg_c[18:14], imm[50:19], zero pad
    input  logic [mre_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    output logic                             o_uop_vld,
    input  logic                             i_uop_rdy,
    output mre_pkg::t_uop                    o_uop
);

    logic          r_vld;
    mre_pkg::t_uop r_uop;
    mre_pkg::t_uop n_uop;
    logic          w_take;

    assign o_s_axis_tready = !r_vld || i_uop_rdy;
    assign w_take          = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_uop          = '0;
        n_uop.cmd      = i_s_axis_tdata[3:0];
        n_uop.reg_a    = i_s_axis_tdata[8:4];
        n_uop.reg_b    = i_s_axis_tdata[13:9];
        n_uop.reg_c    = i_s_axis_tdata[18:14];
        n_uop.imm      = i_s_axis_tdata[50:19];
        n_uop.src2_c   = (n_uop.cmd == mre_pkg::OP_ADD);
        n_uop.is_load  = (n_uop.cmd == mre_pkg::OP_LW);
        n_uop.is_store = (n_uop.cmd == mre_pkg::OP_SW);
        n_uop.illegal  = (n_uop.cmd > mre_pkg::OP_HALT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_take) begin
            r_vld <= 1'b1;
        end else if (i_uop_rdy) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_uop <= n_uop;
        end
    end

    assign o_uop_vld = r_vld;
    assign o_uop     = r_uop;

endmodule

// ===== hw/rtl/mre_queue.sv =====
// Two-entry queue of classified instructions between front and back.
// Depends on mre_pkg for the entry type.
module mre_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mre_pkg::t_uop i_push_uop,
    output logic          o_not_full,
    input  logic          i_pop,
    output logic          o_not_empty,
    output mre_pkg::t_uop o_head
);

    mre_pkg::t_uop r_ent [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_not_full  = (r_cnt != 2'd2);
    assign o_not_empty = (r_cnt != 2'd0);
    assign w_push      = i_push && o_not_full;
    assign w_pop       = i_pop && o_not_empty;
    assign o_head      = r_ent[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_ent[r_wr_ptr] <= i_push_uop;
        end
    end

endmodule

// ===== hw/rtl/mre_back.sv =====
// Back end of the mini RISC executor: register file, data memory, program
// counter, stop status and the result register. Depends on mre_pkg.
module mre_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_vld,
    input  mre_pkg::t_uop                     i_q_uop,
    output logic                              o_q_pop,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output mre_pkg::t_result                  o_res
);

    localparam logic [1:0] ST_RD = 2'd0;
    localparam logic [1:0] ST_EX = 2'd1;
    localparam logic [1:0] ST_WB = 2'd2;

    logic [1:0]                   r_state;
    logic [1:0]                   n_state;
    mre_pkg::t_uop                r_uop;
    logic [mre_pkg::PC_W-1:0]     r_pc;
    logic [1:0]                   r_stop;
    logic [mre_pkg::XLEN-1:0]     r_r1;
    logic [mre_pkg::REG_CNT-1:0]  r_rvld;
    logic [mre_pkg::XLEN-1:0]     r_regs [mre_pkg::REG_CNT];
    logic [mre_pkg::XLEN-1:0]     r_dmem [mre_pkg::DATA_DEPTH];
    logic [mre_pkg::XLEN-1:0]     r_va_raw;
    logic [mre_pkg::XLEN-1:0]     r_vb_raw;
    logic                         r_va_ok;
    logic                         r_vb_ok;
    logic [mre_pkg::XLEN-1:0]     r_dq;
    logic                         r_out_vld;
    mre_pkg::t_result             r_out;

    logic [mre_pkg::RIDX_W-1:0]   w_ra_a;
    logic [mre_pkg::RIDX_W-1:0]   w_ra_b;
    logic [mre_pkg::XLEN-1:0]     w_va;
    logic [mre_pkg::XLEN-1:0]     w_vb;
    logic [mre_pkg::XLEN-1:0]     w_ea;
    logic                         w_oor;
    logic [mre_pkg::DA_W-1:0]     w_dix;
    logic [mre_pkg::PC_W-1:0]     w_pc_inc;
    logic                         w_out_free;
    logic                         w_done;

    logic [mre_pkg::PC_W-1:0]     n_pc;
    logic [1:0]                   n_stop;
    logic                         n_wr;
    logic [mre_pkg::RIDX_W-1:0]   n_widx;
    logic [mre_pkg::XLEN-1:0]     n_wdata;
    logic                         n_st;
    logic                         n_ld;

    assign o_q_pop    = (r_state == ST_RD) && i_q_vld;
    assign w_ra_a     = i_q_uop.src2_c ? i_q_uop.reg_b : i_q_uop.reg_a;
    assign w_ra_b     = i_q_uop.src2_c ? i_q_uop.reg_c : i_q_uop.reg_b;
    // never-written registers read as zero
    assign w_va       = r_va_ok ? r_va_raw : '0;
    assign w_vb       = r_vb_ok ? r_vb_raw : '0;
    assign w_ea       = w_vb + r_uop.imm;
    assign w_oor      = w_ea[mre_pkg::XLEN-1] || (w_ea >= mre_pkg::XLEN'(mre_pkg::DATA_DEPTH));
    assign w_dix      = w_ea[mre_pkg::DA_W-1:0];
    assign w_pc_inc   = r_pc + mre_pkg::PC_W'(1);
    assign w_out_free = !r_out_vld || i_m_axis_tready;

    // execute: work out the next state of one instruction
    always_comb begin
        n_pc    = r_pc;
        n_stop  = r_stop;
        n_wr    = 1'b0;
        n_widx  = r_uop.reg_a;
        n_wdata = '0;
        n_st    = 1'b0;
        n_ld    = 1'b0;
        if (r_stop == mre_pkg::STAT_RUN) begin
            if (r_uop.illegal) begin
                n_stop = mre_pkg::STAT_BADOP;
            end else if ((r_uop.is_load || r_uop.is_store) && w_oor) begin
                n_stop = mre_pkg::STAT_BADADDR;
            end else begin
                case (r_uop.cmd)
                    mre_pkg::OP_NOP: begin
                        n_pc = w_pc_inc;
                    end
                    mre_pkg::OP_ADD: begin
                        n_wr    = 1'b1;
                        n_wdata = w_va + w_vb;
                        n_pc    = w_pc_inc;
                    end
                    mre_pkg::OP_ADDI: begin
                        n_wr    = 1'b1;
                        n_wdata = w_vb + r_uop.imm;
                        n_pc    = w_pc_inc;
                    end
                    mre_pkg::OP_SUBI: begin
                        n_wr    = 1'b1;
                        n_wdata = w_vb - r_uop.imm;
                        n_pc    = w_pc_inc;
                    end
                    mre_pkg::OP_JR: begin
                        n_pc = w_va[mre_pkg::PC_W-1:0];
                    end
                    mre_pkg::OP_JUMP: begin
                        n_pc = r_uop.imm[mre_pkg::PC_W-1:0];
                    end
                    mre_pkg::OP_BEQ: begin
                        n_pc = (w_va == w_vb) ? r_pc + r_uop.imm[mre_pkg::PC_W-1:0] : w_pc_inc;
                    end
                    mre_pkg::OP_LW: begin
                        n_ld = 1'b1;
                    end
                    mre_pkg::OP_SW: begin
                        n_st = 1'b1;
                        n_pc = w_pc_inc;
                    end
                    mre_pkg::OP_LLI: begin
                        n_wr    = 1'b1;
                        n_wdata = r_uop.imm;
                        n_pc    = w_pc_inc;
                    end
                    mre_pkg::OP_BGT: begin
                        n_pc = ($signed(w_va) > $signed(w_vb)) ?
                               r_pc + r_uop.imm[mre_pkg::PC_W-1:0] : w_pc_inc;
                    end
                    mre_pkg::OP_JAL: begin
                        n_wr    = 1'b1;
                        n_widx  = mre_pkg::LINK_REG;
                        n_wdata = mre_pkg::XLEN'(w_pc_inc);
                        n_pc    = r_uop.imm[mre_pkg::PC_W-1:0];
                    end
                    mre_pkg::OP_HALT: begin
                        n_stop = mre_pkg::STAT_HALT;
                    end
                    default: begin
                        n_stop = mre_pkg::STAT_BADOP;
                    end
                endcase
            end
        end
        // load write-back stage
        if (r_state == ST_WB) begin
            n_ld    = 1'b0;
            n_st    = 1'b0;
            n_wr    = 1'b1;
            n_widx  = r_uop.reg_a;
            n_wdata = r_dq;
            n_pc    = w_pc_inc;
            n_stop  = r_stop;
        end
    end

    assign w_done = ((r_state == ST_EX) && !n_ld && w_out_free) ||
                    ((r_state == ST_WB) && w_out_free);

    always_comb begin
        case (r_state)
            ST_RD:   n_state = i_q_vld ? ST_EX : ST_RD;
            ST_EX:   n_state = n_ld ? ST_WB : (w_out_free ? ST_RD : ST_EX);
            ST_WB:   n_state = w_out_free ? ST_RD : ST_WB;
            default: n_state = ST_RD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_RD;
            r_pc      <= '0;
            r_stop    <= mre_pkg::STAT_RUN;
            r_r1      <= '0;
            r_rvld    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_done) begin
                r_pc   <= n_pc;
                r_stop <= n_stop;
                if (n_wr) begin
                    r_rvld[n_widx] <= 1'b1;
                    if (n_widx == mre_pkg::HALT_REG) begin
                        r_r1 <= n_wdata;
                    end
                end
            end
            if (w_done) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_uop    <= i_q_uop;
            r_va_raw <= r_regs[w_ra_a];
            r_vb_raw <= r_regs[w_ra_b];
            r_va_ok  <= r_rvld[w_ra_a];
            r_vb_ok  <= r_rvld[w_ra_b];
        end
        if (w_done && n_wr) begin
            r_regs[n_widx] <= n_wdata;
        end
        if (w_done) begin
            r_out.next_pc    <= n_pc;
            r_out.status     <= n_stop;
            r_out.halt_value <= (n_stop == mre_pkg::STAT_HALT) ? r_r1 : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done && n_st) begin
            r_dmem[w_dix] <= w_va;
        end
        if ((r_state == ST_EX) && n_ld) begin
            r_dq <= r_dmem[w_dix];
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_res           = r_out;

    a_stop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stop != mre_pkg::STAT_RUN) |=> (r_stop == $past(r_stop)))
        else $error("stop status changed after a stop");

    a_pc_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stop != mre_pkg::STAT_RUN) |=> $stable(r_pc))
        else $error("pc moved while stopped");

    a_wb_after_ex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WB) |-> ($past(r_state) == ST_EX || $past(r_state) == ST_WB))
        else $error("write-back entered without an execute step");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_state == ST_EX))
        else $error("popped instruction not executed next");

endmodule
